FILE: sv/audio_jitter_buffer_defines.svh
// assertion macros for the jitter buffer
`ifndef AUDIO_JITTER_BUFFER_DEFINES_SVH
`define AUDIO_JITTER_BUFFER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, checked on every rising clock edge out of reset
`define AJB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define AJB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AJB_ASSERT_IMP(lbl, ante, cons, msg)
`define AJB_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: sv/ajb_pkg.sv
`timescale 1ns / 1ps

package ajb_pkg;

  // transaction kinds on the input channel
  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // pop result codes
  typedef enum logic [1:0] {
    ST_SAMPLE    = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_UNDERRUN  = 2'd2,
    ST_EMPTY_END = 2'd3
  } status_e;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } fsm_e;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned SeqW      = 32;
  localparam int unsigned MaxSampW  = 9;
  localparam int unsigned DepthW    = 4;

  typedef struct packed {
    kind_e                       kind;
    logic [SeqW-1:0]             sequence_req;
    logic signed [SampleW-1:0]   sample_in;
    logic                        last_in;
    logic [MaxSampW-1:0]         pop_limit;
  } in_item_t;

  typedef struct packed {
    status_e                     status;
    logic signed [SampleW-1:0]   sample_out;
    logic                        last_out;
    logic                        ready_res;
  } out_item_t;

endpackage

FILE: sv/audio_jitter_buffer.sv
`timescale 1ns / 1ps
`include "audio_jitter_buffer_defines.svh"

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   in_item_i  (ajb_pkg::in_item_t)
// out       output     out_valid_o / out_ready_i out_item_o (ajb_pkg::out_item_t)
// cfg       input      cfg_we_i                  cfg_wdata_i (playout depth)
//
// push and clear transactions complete as they are accepted; a pop first does the
// synchronous read of the sample memory and the count memory, then forms the result in S_POP.
// the pop result sits in an output register; pushes are accepted while it waits.
// a pop stalls in the S_POP state only while the output register is full and not taken.
// reset clears the valid bits, pointers and counters at once; the memories keep
// their contents and need no clearing pass.

module audio_jitter_buffer #(
  parameter int unsigned CAPACITY  = 8,
  parameter int unsigned FRAME_LEN = 320
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ajb_pkg::in_item_t      in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ajb_pkg::out_item_t     out_item_o,
  input  logic                   cfg_we_i,
  input  logic [ajb_pkg::DepthW-1:0] cfg_wdata_i
);

  import ajb_pkg::*;

  localparam int unsigned SW    = $clog2(CAPACITY);
  localparam int unsigned BW    = $clog2(CAPACITY + 1);
  localparam int unsigned OW    = $clog2(FRAME_LEN + 1);
  localparam int unsigned CW    = (OW > MaxSampW) ? OW : MaxSampW;
  localparam int unsigned TW    = (BW > DepthW) ? BW : DepthW;
  localparam int unsigned Depth = CAPACITY * FRAME_LEN;
  localparam int unsigned AW    = $clog2(Depth);

  localparam logic [SW-1:0] LastSlot = SW'(CAPACITY - 1);
  localparam logic [BW-1:0] CapB     = BW'(CAPACITY);
  localparam logic [OW-1:0] FrameO   = OW'(FRAME_LEN);
  localparam logic [AW-1:0] FrameA   = AW'(FRAME_LEN);

  // memories
  logic [SampleW-1:0] smp_mem [Depth];
  logic [OW-1:0]      cnt_mem [CAPACITY];

  // control state
  fsm_e                 state_q, state_d;
  logic [DepthW-1:0]    depth_q;
  logic [CAPACITY-1:0]  valid_q, valid_d;
  logic [SeqW-1:0]      play_seq_q, play_seq_d;
  logic [SW-1:0]        wr_slot_q, wr_slot_d;
  logic [SW-1:0]        rd_slot_q, rd_slot_d;
  logic [BW-1:0]        bf_q, bf_d;
  logic                 started_q, started_d;
  logic [OW-1:0]        push_off_q, push_off_d;
  logic                 dropping_q, dropping_d;
  logic [OW-1:0]        pop_off_q, pop_off_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_item_q, out_item_d;

  // pop operands captured at accept
  logic [MaxSampW-1:0]  maxs_q;
  logic [SampleW-1:0]   smp_rd_q;
  logic [OW-1:0]        cnt_rd_q;

  // memory ports
  logic                 smp_we;
  logic [AW-1:0]        smp_waddr;
  logic [AW-1:0]        smp_raddr;
  logic                 cnt_we;
  logic [OW-1:0]        cnt_wdata;

  logic                 in_fire;
  logic                 pop_acc;
  logic                 pop_fire;

  // pop evaluation
  logic [CW-1:0]        pop_n;
  logic [CW-1:0]        pop_off_c;
  logic                 pop_empty_end;
  logic                 pop_last;

  assign in_fire = in_valid_i && in_ready_o;
  assign pop_acc = in_fire && (in_item_i.kind == KIND_POP);

  // fsm next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (pop_acc) state_d = S_POP;
      end
      S_POP: begin
        if (pop_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready_o = 1'b0;
    pop_fire   = 1'b0;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_POP:  pop_fire   = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        pop_fire   = 1'b0;
      end
    endcase
  end

  // pop length and end-of-frame tests
  always_comb begin
    pop_n = (CW'(maxs_q) < CW'(cnt_rd_q)) ? CW'(maxs_q) : CW'(cnt_rd_q);
    pop_off_c     = CW'(pop_off_q);
    pop_empty_end = pop_off_c >= pop_n;
    pop_last      = CW'(pop_off_c + CW'(1)) >= pop_n;
  end

  // state update for push, clear and pop
  always_comb begin
    logic end_frame;
    logic do_write;
    end_frame   = 1'b0;
    do_write    = 1'b0;
    valid_d     = valid_q;
    play_seq_d  = play_seq_q;
    wr_slot_d   = wr_slot_q;
    rd_slot_d   = rd_slot_q;
    bf_d        = bf_q;
    started_d   = started_q;
    push_off_d  = push_off_q;
    dropping_d  = dropping_q;
    pop_off_d   = pop_off_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    smp_we      = 1'b0;
    smp_waddr   = AW'(wr_slot_q) * FrameA + AW'(push_off_q);
    cnt_we      = 1'b0;
    cnt_wdata   = push_off_q;

    // push, clear
    if (in_fire) begin
      case (in_item_i.kind)
        KIND_PUSH: begin
          if (push_off_q == '0 && !dropping_q) begin
            if (started_q && in_item_i.sequence_req < play_seq_q) begin
              dropping_d = !in_item_i.last_in;
            end else begin
              if (!started_q) begin
                play_seq_d = in_item_i.sequence_req;
                started_d  = 1'b1;
              end
              do_write = 1'b1;
            end
          end else if (dropping_q) begin
            if (in_item_i.last_in) dropping_d = 1'b0;
          end else begin
            do_write = 1'b1;
          end
          if (do_write) begin
            if (push_off_q < FrameO) begin
              smp_we     = 1'b1;
              push_off_d = push_off_q + OW'(1);
            end
            if (in_item_i.last_in) begin
              cnt_we               = 1'b1;
              cnt_wdata            = push_off_d;
              valid_d[wr_slot_q]   = 1'b1;
              wr_slot_d = (wr_slot_q == LastSlot) ? '0 : wr_slot_q + SW'(1);
              if (bf_q < CapB) bf_d = bf_q + BW'(1);
              push_off_d = '0;
            end
          end
        end
        KIND_CLEAR: begin
          valid_d    = '0;
          play_seq_d = '0;
          wr_slot_d  = '0;
          rd_slot_d  = '0;
          bf_d       = '0;
          started_d  = 1'b0;
          push_off_d = '0;
          dropping_d = 1'b0;
          pop_off_d  = '0;
        end
        KIND_POP:  ;
        KIND_NONE: ;
        default:   ;
      endcase
    end

    // pop result
    if (pop_fire) begin
      out_valid_d           = 1'b1;
      out_item_d.status     = ST_SAMPLE;
      out_item_d.sample_out = '0;
      out_item_d.last_out   = 1'b0;
      if (pop_off_q == '0 && TW'(bf_q) < TW'(depth_q)) begin
        out_item_d.status = ST_NOT_READY;
      end else if (!valid_q[rd_slot_q]) begin
        out_item_d.status = ST_UNDERRUN;
      end else if (pop_empty_end) begin
        out_item_d.status   = ST_EMPTY_END;
        out_item_d.last_out = 1'b1;
        end_frame           = 1'b1;
      end else begin
        out_item_d.sample_out = smp_rd_q;
        if (pop_last) begin
          out_item_d.last_out = 1'b1;
          end_frame           = 1'b1;
        end else begin
          pop_off_d = pop_off_q + OW'(1);
        end
      end
      // free the head slot
      if (end_frame) begin
        valid_d[rd_slot_q] = 1'b0;
        rd_slot_d  = (rd_slot_q == LastSlot) ? '0 : rd_slot_q + SW'(1);
        if (bf_q != '0) bf_d = bf_q - BW'(1);
        play_seq_d = play_seq_q + SeqW'(1);
        pop_off_d  = '0;
      end
      out_item_d.ready_res = TW'(bf_d) >= TW'(depth_q);
    end
  end

  assign smp_raddr = AW'(rd_slot_q) * FrameA + AW'(pop_off_q);

  // sample memory
  always_ff @(posedge clk_i) begin
    if (smp_we) smp_mem[smp_waddr] <= in_item_i.sample_in;
    if (pop_acc) smp_rd_q <= smp_mem[smp_raddr];
  end

  // frame length memory
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[wr_slot_q] <= cnt_wdata;
    if (pop_acc) cnt_rd_q <= cnt_mem[rd_slot_q];
  end

  // pop operand and result payload
  always_ff @(posedge clk_i) begin
    if (pop_acc) maxs_q <= in_item_i.pop_limit;
    out_item_q <= out_item_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= DepthW'(2);
      valid_q     <= '0;
      play_seq_q  <= '0;
      wr_slot_q   <= '0;
      rd_slot_q   <= '0;
      bf_q        <= '0;
      started_q   <= 1'b0;
      push_off_q  <= '0;
      dropping_q  <= 1'b0;
      pop_off_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) depth_q <= cfg_wdata_i;
      valid_q     <= valid_d;
      play_seq_q  <= play_seq_d;
      wr_slot_q   <= wr_slot_d;
      rd_slot_q   <= rd_slot_d;
      bf_q        <= bf_d;
      started_q   <= started_d;
      push_off_q  <= push_off_d;
      dropping_q  <= dropping_d;
      pop_off_q   <= pop_off_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // checks
  `AJB_ASSERT_IMP(a_bf_cap, 1'b1, bf_q <= CapB, "buffered frame count above capacity")
  `AJB_ASSERT_IMP(a_pop_block, state_q == S_POP, !in_ready_o, "input taken during pop")
  `AJB_ASSERT_NXT(a_pop_enter, pop_acc, state_q == S_POP, "pop transaction did not start")
  `AJB_ASSERT_IMP(a_zero_smp, out_valid_o && out_item_o.status != ST_SAMPLE, out_item_o.sample_out == '0, "nonzero sample without data")

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import ajb_pkg::*;

  localparam int unsigned CAP        = 8;
  localparam int unsigned FLEN       = 320;
  localparam int unsigned SlotW      = $clog2(CAP);
  localparam int unsigned PhaseItems = 180;
  localparam out_item_t   NoWant     = '0;

  // one line of the directed table: a depth write or an input transaction
  typedef struct {
    bit                is_cfg;
    logic [DepthW-1:0] depth;
    in_item_t          item;
    bit                fixed;
    out_item_t         want;
  } stim_row_t;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_item;
  logic              cfg_we    = 1'b0;
  logic [DepthW-1:0] cfg_wdata = '0;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned fail_count   = 0;

  logic [DepthW-1:0] phase_depth [6] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd4, 4'd2};

  // jitter buffer shadow state
  logic [SampleW-1:0]  pcm_mem [CAP*FLEN];
  logic [MaxSampW-1:0] slot_len [CAP];
  bit                  slot_full [CAP];
  logic [SeqW-1:0]     play_seq       = '0;
  logic [SlotW-1:0]    wr_slot        = '0;
  logic [SlotW-1:0]    rd_slot        = '0;
  logic [DepthW-1:0]   frames_held    = '0;
  logic                has_started    = 1'b0;
  logic                dropping_frame = 1'b0;
  logic [MaxSampW-1:0] push_pos       = '0;
  logic [MaxSampW-1:0] pop_pos        = '0;
  logic [DepthW-1:0]   depth_cfg      = 4'd2;

  out_item_t pending_pops [$];
  out_item_t want;
  stim_row_t directed [$];

  audio_jitter_buffer #(
    .CAPACITY (CAP),
    .FRAME_LEN(FLEN)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic in_item_t mk_item(kind_e k, logic [SeqW-1:0] seq,
                                       logic [SampleW-1:0] smp, logic last,
                                       logic [MaxSampW-1:0] maxs);
    in_item_t it;
    it.kind         = k;
    it.sequence_req = seq;
    it.sample_in    = smp;
    it.last_in      = last;
    it.pop_limit    = maxs;
    return it;
  endfunction

  // apply one accepted transaction to the shadow buffer, queue the pop result
  function automatic void buffer_step(input in_item_t it);
    logic [MaxSampW-1:0] n;
    int unsigned         ws;
    int unsigned         rs;
    bit                  skip;
    bit                  frame_done;
    out_item_t           r;
    ws         = wr_slot;
    rs         = rd_slot;
    skip       = 1'b0;
    frame_done = 1'b0;
    r          = '0;
    case (it.kind)
      KIND_PUSH: begin
        // frame start: late frames are dropped, the first one sets playout
        if (push_pos == 0 && !dropping_frame) begin
          if (has_started && it.sequence_req < play_seq) begin
            dropping_frame = !it.last_in;
            skip = 1'b1;
          end else if (!has_started) begin
            play_seq    = it.sequence_req;
            has_started = 1'b1;
          end
        end else if (dropping_frame) begin
          if (it.last_in) dropping_frame = 1'b0;
          skip = 1'b1;
        end
        if (!skip) begin
          // samples past the slot length are ignored
          if (push_pos < FLEN) begin
            pcm_mem[ws*FLEN + push_pos] = it.sample_in;
            push_pos++;
          end
          if (it.last_in) begin
            slot_len[ws]  = push_pos;
            slot_full[ws] = 1'b1;
            wr_slot       = SlotW'((ws + 1) % CAP);
            if (frames_held < CAP) frames_held++;
            push_pos      = '0;
          end
        end
      end
      KIND_POP: begin
        if (pop_pos == 0 && frames_held < depth_cfg) begin
          r.status = ST_NOT_READY;
        end else if (!slot_full[rs]) begin
          r.status = ST_UNDERRUN;
        end else begin
          n = slot_len[rs];
          if (n > FLEN) n = FLEN;
          if (it.pop_limit < n) n = it.pop_limit;
          if (pop_pos >= n) begin
            r.status   = ST_EMPTY_END;
            r.last_out = 1'b1;
            frame_done = 1'b1;
          end else begin
            r.sample_out = pcm_mem[rs*FLEN + pop_pos];
            if (pop_pos + 1 >= n) begin
              r.last_out = 1'b1;
              frame_done = 1'b1;
            end else begin
              pop_pos++;
            end
          end
          // head frame finished: free the slot and step the playout sequence
          if (frame_done) begin
            slot_full[rs] = 1'b0;
            rd_slot       = SlotW'((rs + 1) % CAP);
            if (frames_held > 0) frames_held--;
            play_seq++;
            pop_pos       = '0;
          end
        end
        r.ready_res = (frames_held >= depth_cfg);
        pending_pops.push_back(r);
      end
      KIND_CLEAR: begin
        foreach (slot_full[i]) slot_full[i] = 1'b0;
        play_seq       = '0;
        wr_slot        = '0;
        rd_slot        = '0;
        frames_held    = '0;
        has_started    = 1'b0;
        push_pos       = '0;
        dropping_frame = 1'b0;
        pop_pos        = '0;
      end
      default: ;
    endcase
  endfunction

  // drive one input transaction, with a random gap in front of it
  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    buffer_step(it);
  endtask

  // hold off the input until every pop result is back and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pops.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_depth(input logic [DepthW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    depth_cfg  = v;
  endtask

  // receiver stalls and result check
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= snk_idle_pct);
    if (rst_ni && out_valid && out_ready) begin
      if (pending_pops.size() == 0) begin
        $error("pop result with no pop outstanding");
        fail_count++;
      end else begin
        want = pending_pops.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fail_count++;
        end
        if (out_item.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d", want.sample_out, out_item.sample_out);
          fail_count++;
        end
        if (out_item.last_out !== want.last_out) begin
          $error("last_out: expected %0d, got %0d", want.last_out, out_item.last_out);
          fail_count++;
        end
        if (out_item.ready_res !== want.ready_res) begin
          $error("ready_res: expected %0d, got %0d", want.ready_res, out_item.ready_res);
          fail_count++;
        end
      end
    end
  end

  initial begin
    in_item_t            it;
    int unsigned         r;
    int unsigned         sent;
    int unsigned         frame_left;
    logic [SeqW-1:0]     frame_seq;

    frame_left = 0;
    frame_seq  = '0;

    directed = '{
      // pop before any frame
      '{1'b0, '0, mk_item(KIND_POP, '0, '0, 1'b0, '0), 1'b1,
        '{ST_NOT_READY, '0, 1'b0, 1'b0}},
      // first frame latches the top sequence number, extreme samples
      '{1'b0, '0, mk_item(KIND_PUSH, '1, 16'h7fff, 1'b0, '1), 1'b0, NoWant},
      '{1'b0, '0, mk_item(KIND_PUSH, '1, 16'h8000, 1'b1, '0), 1'b0, NoWant},
      '{1'b0, '0, mk_item(KIND_POP, '0, '0, 1'b0, 9'd320), 1'b1,
        '{ST_NOT_READY, '0, 1'b0, 1'b0}},
      // late frames dropped, one sample long and two samples long
      '{1'b0, '0, mk_item(KIND_PUSH, 32'd5, 16'd1, 1'b1, '0), 1'b0, NoWant},
      '{1'b0, '0, mk_item(KIND_PUSH, 32'd3, 16'd2, 1'b0, '0), 1'b0, NoWant},
      '{1'b0, '0, mk_item(KIND_PUSH, '1, 16'd3, 1'b1, '0), 1'b0, NoWant},
      '{1'b0, '0, mk_item(KIND_PUSH, '1, 16'hffff, 1'b1, '0), 1'b0, NoWant},
      '{1'b0, '0, mk_item(KIND_POP, '0, '0, 1'b0, '1), 1'b1,
        '{ST_SAMPLE, 16'sh7fff, 1'b0, 1'b1}},
      // end of frame wraps the playout sequence to zero
      '{1'b0, '0, mk_item(KIND_POP, '0, '0, 1'b0, '1), 1'b1,
        '{ST_SAMPLE, 16'sh8000, 1'b1, 1'b0}},
      '{1'b0, '0, mk_item(KIND_POP, '0, '0, 1'b0, '1), 1'b1,
        '{ST_NOT_READY, '0, 1'b0, 1'b0}},
      '{1'b0, '0, mk_item(KIND_PUSH, 32'd0, 16'd100, 1'b1, '0), 1'b0, NoWant},
      // zero pop limit ends the head frame with no sample
      '{1'b0, '0, mk_item(KIND_POP, '0, '0, 1'b0, '0), 1'b1,
        '{ST_EMPTY_END, '0, 1'b1, 1'b0}},
      // later sequence numbers in a frame are ignored
      '{1'b0, '0, mk_item(KIND_PUSH, 32'h12345678, 16'h5a5a, 1'b0, '0), 1'b0, NoWant},
      '{1'b0, '0, mk_item(KIND_PUSH, 32'd0, 16'h0f0f, 1'b0, '0), 1'b0, NoWant},
      '{1'b0, '0, mk_item(KIND_PUSH, 32'hffff0000, 16'h1234, 1'b1, '0), 1'b0, NoWant},
      '{1'b0, '0, mk_item(KIND_POP, '0, '0, 1'b0, 9'd2), 1'b0, NoWant},
      '{1'b0, '0, mk_item(KIND_POP, '0, '0, 1'b0, 9'd1), 1'b0, NoWant},
      // buffer clear, then an ignored kind
      '{1'b0, '0, mk_item(KIND_CLEAR, '0, '0, 1'b0, '0), 1'b0, NoWant},
      '{1'b0, '0, mk_item(KIND_NONE, '1, '1, 1'b1, '1), 1'b0, NoWant},
      // depth zero: always ready, so an empty head slot underruns
      '{1'b1, 4'd0, '0, 1'b0, NoWant},
      '{1'b0, '0, mk_item(KIND_POP, '0, '0, 1'b0, 9'd5), 1'b1,
        '{ST_UNDERRUN, '0, 1'b0, 1'b1}},
      '{1'b0, '0, mk_item(KIND_PUSH, 32'd7, 16'd9, 1'b1, '0), 1'b0, NoWant},
      '{1'b0, '0, mk_item(KIND_POP, '0, '0, 1'b0, 9'd320), 1'b1,
        '{ST_SAMPLE, 16'sd9, 1'b1, 1'b1}}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    src_idle_pct = 27;
    snk_idle_pct = 45;
    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        settle();
        write_depth(directed[i].depth);
      end else begin
        send_item(directed[i].item);
        if (directed[i].fixed) begin
          void'(pending_pops.pop_back());
          pending_pops.push_back(directed[i].want);
        end
      end
    end

    // random phases, each at its own depth, with the idling mix changing every two phases
    for (int p = 0; p < 6; p++) begin
      settle();
      write_depth(phase_depth[p]);
      src_idle_pct = (p < 2) ? 27 : (p < 4) ? 45 : 0;
      snk_idle_pct = (p < 2) ? 45 : (p < 4) ? 27 : 0;
      // one frame longer than a slot, pushed amid the other traffic
      if (p == 4) begin
        if (frame_left == 0) frame_seq = play_seq;
        frame_left = frame_left + FLEN + 2;
      end
      sent = 0;
      while (sent < PhaseItems) begin
        r  = $urandom_range(99);
        it = mk_item(KIND_POP, $urandom(), SampleW'($urandom()),
                     1'($urandom_range(1)), MaxSampW'($urandom_range(511)));
        if (frame_left == 0 && r < 40) begin
          // new frame, mostly in sequence, some late, some anywhere
          frame_left = ($urandom_range(99) < 85) ? $urandom_range(6, 1)
                                                 : $urandom_range(40, 7);
          r = $urandom_range(99);
          frame_seq = (r < 80) ? play_seq + $urandom_range(3) :
                      (r < 92) ? play_seq - $urandom_range(4, 1) : $urandom();
          r = 0;
        end
        if (frame_left != 0 && r < 60) begin
          it.kind = KIND_PUSH;
          if ($urandom_range(9) != 0) it.sequence_req = frame_seq;
          it.last_in = (frame_left == 1);
          frame_left--;
        end else if (r < 88) begin
          r = $urandom_range(99);
          if (r < 65) it.pop_limit = MaxSampW'($urandom_range(511, 256));
          else if (r < 85) it.pop_limit = MaxSampW'($urandom_range(6, 0));
        end else if (r < 93 && frame_left < 41) begin
          it.kind = KIND_CLEAR;
        end else if (r < 96) begin
          it.kind = KIND_NONE;
        end else if (frame_left == 0) begin
          // stray sample with random sequence and end marker
          it.kind = KIND_PUSH;
        end
        send_item(it);
        if (it.kind != KIND_NONE) sent++;
      end
    end

    settle();
    repeat (6) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("audio_jitter_buffer verification clean");
    end else begin
      $display("audio_jitter_buffer verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #400_000;
    $display("audio_jitter_buffer verification failed");
    $finish;
  end

endmodule
